// ----- rtl/core/tcce_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the text console character engine
// no dependencies; imported by every module of the block

package tcce_pkg;

  // fixed field widths
  localparam int unsigned CharW      = 8;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned CellW      = 16;
  localparam int unsigned ReadIdxW   = 11;
  localparam int unsigned CursorPosW = 11;

  // character codes
  localparam logic [CharW-1:0] CharNewline   = 8'd10;
  localparam logic [CharW-1:0] CharBackspace = 8'd8;
  localparam logic [CharW-1:0] CharSpace     = 8'd32;

  // reset values
  localparam logic [CellW-1:0]  ResetCell  = 16'h0720;
  localparam logic [ColorW-1:0] ResetColor = 8'd7;

  // item operation
  typedef enum logic [0:0] {
    OpPut  = 1'b0,
    OpRead = 1'b1
  } op_e;

  // input transaction payload
  typedef struct packed {
    op_e                 op;
    logic [CharW-1:0]    char_code;
    logic [ReadIdxW-1:0] read_index;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic [CellW-1:0]      cell_value;
    logic [CursorPosW-1:0] cursor_pos;
    logic                  scrolled;
  } out_item_t;

endpackage

// ----- rtl/core/tcce_screen_mem.sv -----
`timescale 1ns / 1ps
// screen cell store: one write port, one read port, registered read data
// depends on tcce_pkg for the cell width

module tcce_screen_mem
  import tcce_pkg::*;
#(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [CellW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [CellW-1:0] rdata_o
);

  logic [CellW-1:0] mem_q [Depth];
  logic [CellW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tcce_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: cursor, color register, clear pass, put/read handling, scroll sweep
// depends on tcce_pkg; drives the ports of tcce_screen_mem

module tcce_ctrl
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  in_item_t                              in_item_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ColorW-1:0]                     cfg_data_i,
  output logic                                  mem_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_waddr_o,
  output logic [CellW-1:0]                      mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_raddr_o,
  input  logic [CellW-1:0]                      mem_rdata_i,
  output logic                                  res_valid_o,
  output out_item_t                             res_item_o,
  input  logic                                  slot_free_i
);

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned CntW      = $clog2(CellCount + 1);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned ColW      = $clog2(COLUMNS);

  localparam logic [RowW-1:0] LastRow   = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] LastCol   = ColW'(COLUMNS - 1);
  localparam logic [CntW-1:0] ClearLast = CntW'(CellCount - 1);
  localparam logic [CntW-1:0] CopyEnd   = CntW'(CellCount - COLUMNS);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StReadWait,
    StCopy,
    StFill,
    StEmit
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [ColorW-1:0]  color_q;
  logic [CellW-1:0]   cell_q, cell_d;
  logic               scrolled_q, scrolled_d;

  logic [AddrW-1:0]   cur_addr;
  logic [CellW-1:0]   blank_cell;
  logic               do_scroll;

  // linear cursor address, shared by writes and the reported position
  assign cur_addr   = AddrW'(row_q) * AddrW'(COLUMNS) + AddrW'(col_q);
  assign blank_cell = {color_q, CharSpace};

  assign cfg_ready_o = 1'b1;

  // next state, cursor update and memory access
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    cell_d      = cell_q;
    scrolled_d  = scrolled_q;
    do_scroll   = 1'b0;
    in_stall_o  = 1'b1;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      // sweep the reset value through every cell
      StClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(cnt_q);
        mem_wdata_o = ResetCell;
        if (cnt_q == ClearLast) begin
          cnt_d   = '0;
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cell_d     = '0;
          scrolled_d = 1'b0;
          if (in_item_i.op == OpRead) begin
            if (32'(in_item_i.read_index) < 32'(CellCount)) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrW'(in_item_i.read_index);
              state_d     = StReadWait;
            end else begin
              state_d = StEmit;
            end
          end else begin
            case (in_item_i.char_code)
              CharNewline: begin
                col_d = '0;
                if (row_q == LastRow) begin
                  do_scroll = 1'b1;
                end else begin
                  row_d = row_q + RowW'(1);
                end
              end
              CharBackspace: begin
                // cell before the cursor, also across a line start
                if (col_q != '0) begin
                  col_d       = col_q - ColW'(1);
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cur_addr - AddrW'(1);
                  mem_wdata_o = blank_cell;
                end else if (row_q != '0) begin
                  row_d       = row_q - RowW'(1);
                  col_d       = LastCol;
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cur_addr - AddrW'(1);
                  mem_wdata_o = blank_cell;
                end
              end
              default: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cur_addr;
                mem_wdata_o = {color_q, in_item_i.char_code};
                if (col_q == LastCol) begin
                  col_d = '0;
                  if (row_q == LastRow) begin
                    do_scroll = 1'b1;
                  end else begin
                    row_d = row_q + RowW'(1);
                  end
                end else begin
                  col_d = col_q + ColW'(1);
                end
              end
            endcase
            if (do_scroll) begin
              scrolled_d = 1'b1;
              cnt_d      = '0;
              state_d    = StCopy;
            end else begin
              state_d = StEmit;
            end
          end
        end
      end

      StReadWait: begin
        cell_d  = mem_rdata_i;
        state_d = StEmit;
      end

      // move every row up: read one row ahead, write the data back in the next cycle
      StCopy: begin
        if (cnt_q < CopyEnd) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(cnt_q + CntW'(COLUMNS));
        end
        if (cnt_q != '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(cnt_q - CntW'(1));
          mem_wdata_o = mem_rdata_i;
        end
        if (cnt_q == CopyEnd) begin
          state_d = StFill;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      // blank the freed bottom row
      StFill: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(cnt_q);
        mem_wdata_o = blank_cell;
        if (cnt_q == ClearLast) begin
          cnt_d   = '0;
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      StEmit: begin
        if (slot_free_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // result toward the output register
  assign res_valid_o           = (state_q == StEmit) && slot_free_i;
  assign res_item_o.cell_value = cell_q;
  assign res_item_o.cursor_pos = CursorPosW'(cur_addr);
  assign res_item_o.scrolled   = scrolled_q;

  // state, cursor and registered result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      cnt_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      scrolled_q <= 1'b0;
      cell_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      scrolled_q <= scrolled_d;
      cell_q     <= cell_d;
    end
  end

  // color register write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ResetColor;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

`ifndef SYNTHESIS
  // cursor never leaves the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LastRow) && (col_q <= LastCol))
    else $error("cursor out of range");

  // the scroll sweep never reads the cell it writes in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write hit the same cell");

  // a scroll leaves the cursor on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> (row_q == LastRow) && scrolled_q)
    else $error("scroll with cursor off the bottom row");

  // after a result is handed over the engine is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == StIdle))
    else $error("result not followed by idle");
`endif

endmodule

// ----- rtl/core/text_console_char_engine_unit.sv -----
`timescale 1ns / 1ps
// top level of the text console character engine: sequencer, cell store, output register
// depends on tcce_pkg, tcce_ctrl and tcce_screen_mem

// Text console character engine.
// Input channel (in_valid_i / in_stall_o / in_item_i): a put item writes a
// character at the cursor (newline and backspace handled), a read item returns
// one cell. Each item gives exactly one result on the output channel
// (out_valid_o / out_stall_i / out_item_o) with the cell read (0 on a put), the
// linear cursor position and a scroll flag.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the attribute
// byte used for printed characters and blanks; ready is always high.
// Sequence: a put passes through StEmit, a read through StReadWait (for the
// registered memory read) and then StEmit; the result is loaded into the output
// register from StEmit, and the next item is taken once back in StIdle.
// A put that runs past the last row scrolls by copying the store through the
// single read and write port, one cell per cycle, then blanks the bottom row;
// input stays stalled meanwhile.
// Reset: the cursor goes to the top-left cell and a clearing pass writes
// 0x0720 to all ROWS*COLUMNS cells, one per cycle; input stays stalled
// during that pass.
// The output register holds a result while the receiver stalls; the engine
// takes the next item meanwhile and waits only when its own result is ready.

module text_console_char_engine_unit
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ColorW-1:0] cfg_data_i
);

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [CellW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [CellW-1:0] mem_rdata;
  logic             res_valid;
  out_item_t        res_item;
  logic             slot_free;
  logic             out_valid_q;
  out_item_t        out_item_q;

  tcce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .slot_free_i (slot_free)
  );

  tcce_screen_mem #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_screen_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register frees when empty or when its transaction completes
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
